// File: sv/aes128_gcm_decrypt_unit_defines.svh
// assertion macros shared by the aes128 gcm decrypt unit rtl
// no dependencies; included by the files that carry assertions
`ifndef AES128_GCM_DECRYPT_UNIT_DEFINES_SVH
`define AES128_GCM_DECRYPT_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define AGD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define AGD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: sv/agd_pkg.sv
// shared types, constants and functions of the aes128 gcm decrypt unit
// no dependencies
package agd_pkg;

   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_DATA   = 2'd1,
      CMD_FINISH = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_KEY_HIGH   = 2'd0,
      CSR_KEY_LOW    = 2'd1,
      CSR_NONCE_HIGH = 2'd2,
      CSR_NONCE_LOW  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic expand;
      logic encrypt;
   } aes_ctl_type;

   localparam int TAG_LENGTH_DEF = 16;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] RCON [11] = '{
      8'h8d,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   // ghash reduction constant, placed in the top byte
   localparam logic [7:0] GF_POLY = 8'he1;

   // mask with the leading n bytes set, byte 0 in the top bits
   function automatic logic [127:0] lead_mask(input logic [4:0] n);
      logic [127:0] m;
      m = '0;
      for (int i = 0; i < 16; i++) begin
         m[127 - 8*i -: 8] = (i < int'(n)) ? 8'hff : 8'h00;
      end
      return m;
   endfunction

endpackage

// File: sv/aes128_gcm_decrypt_unit.sv
// top level of the aes128 gcm decrypt unit: command sequencer and gcm state
// depends on agd_pkg, agd_aes_core, agd_ghash_mul and the assertion macro header
//
// usage
//   csr channel: csr_index selects key_high, key_low, nonce_high, nonce_low;
//   csr_ready is always high. key and nonce are latched by a start command.
//   req channel: one command per transfer (start, ciphertext block, finish).
//   rsp channel: exactly one result per command, except command code three,
//   which is dropped with no result.
// sequencing
//   start: 10 key schedule steps, then the encryption of the zero block
//   for the hash key. ciphertext block and finish: the bytewise ghash
//   multiplier runs beside the one-round-per-cycle aes core and ends last.
//   a ciphertext block with zero bytes uses neither unit.
// throughput: one command at a time; req_ready is high only when idle
// reset: synchronous; clears the sequencer, counter, length and accumulator.
// stall: a result waits in the rsp register until taken; the block holds
// the finished result and takes no new command until it has been loaded.
`include "aes128_gcm_decrypt_unit_defines.svh"
module aes128_gcm_decrypt_unit #(
   parameter int TAG_LENGTH = agd_pkg::TAG_LENGTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_data_high,
   input  logic [63:0] req_data_low,
   input  logic [4:0]  req_byte_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [63:0] rsp_plain_high,
   output logic [63:0] rsp_plain_low,
   output logic [4:0]  rsp_valid_bytes,
   output logic        rsp_tag_ok
);
   import agd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_HASHKEY,
      ST_RUN,
      ST_RESP
   } top_state_type;

   localparam logic [127:0] TAG_MASK = lead_mask(5'(TAG_LENGTH));

   // configuration registers
   logic [63:0]   key_high_ff, key_low_ff, nonce_high_ff;
   logic [31:0]   nonce_low_ff;

   top_state_type state_ff, state_in;
   logic [95:0]   nonce_held_ff, nonce_held_in;
   logic [127:0]  h_ff, h_in;
   logic [127:0]  acc_ff, acc_in;
   logic [31:0]   ctr_ff, ctr_in;
   logic [63:0]   len_ff, len_in;
   cmd_type       cmd_ff, cmd_in;
   logic [127:0]  data_ff, data_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic          aes_flag_ff, aes_flag_in;
   logic          gh_flag_ff, gh_flag_in;
   logic [1:0]    res_kind_ff, res_kind_in;
   logic [127:0]  res_plain_ff, res_plain_in;
   logic [4:0]    res_bytes_ff, res_bytes_in;
   logic          res_tag_ff, res_tag_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_kind_ff;
   logic [127:0]  rsp_plain_ff;
   logic [4:0]    rsp_bytes_ff;
   logic          rsp_tag_ff;
   logic          rsp_load;

   aes_ctl_type   aes_ctl;
   logic [127:0]  aes_block;
   logic          aes_done;
   logic [127:0]  aes_result;
   logic          gh_go;
   logic [127:0]  gh_x;
   logic          gh_done;
   logic [127:0]  gh_product;

   logic          req_xfer;
   cmd_type       req_cmd;
   logic [4:0]    nsat;
   logic [127:0]  req_mask;
   logic [127:0]  req_masked;
   logic [127:0]  tag_diff;

   assign csr_ready  = 1'b1;
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_xfer   = req_valid && req_ready;
   assign req_cmd    = cmd_type'(req_command);
   assign nsat       = (req_byte_count > 5'd16) ? 5'd16 : req_byte_count;
   assign req_mask   = lead_mask(nsat);
   assign req_masked = {req_data_high, req_data_low} & req_mask;
   assign tag_diff   = (aes_result ^ gh_product ^ data_ff) & TAG_MASK;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff   <= '0;
         key_low_ff    <= '0;
         nonce_high_ff <= '0;
         nonce_low_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_HIGH:   key_high_ff   <= csr_data;
            CSR_KEY_LOW:    key_low_ff    <= csr_data;
            CSR_NONCE_HIGH: nonce_high_ff <= csr_data;
            CSR_NONCE_LOW:  nonce_low_ff  <= csr_data[31:0];
            default:        key_high_ff   <= key_high_ff;
         endcase
      end
   end

   // command sequencer
   always_comb begin
      state_in      = state_ff;
      nonce_held_in = nonce_held_ff;
      h_in          = h_ff;
      acc_in        = acc_ff;
      ctr_in        = ctr_ff;
      len_in        = len_ff;
      cmd_in        = cmd_ff;
      data_in       = data_ff;
      cnt_in        = cnt_ff;
      aes_flag_in   = aes_flag_ff || aes_done;
      gh_flag_in    = gh_flag_ff || gh_done;
      res_kind_in   = res_kind_ff;
      res_plain_in  = res_plain_ff;
      res_bytes_in  = res_bytes_ff;
      res_tag_in    = res_tag_ff;
      aes_ctl       = '0;
      aes_block     = {nonce_held_ff, ctr_ff};
      gh_go         = 1'b0;
      gh_x          = acc_ff ^ req_masked;
      rsp_load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cmd_in       = req_cmd;
               data_in      = req_masked;
               cnt_in       = nsat;
               res_kind_in  = req_command;
               res_plain_in = '0;
               res_bytes_in = '0;
               res_tag_in   = 1'b0;
               aes_flag_in  = 1'b0;
               gh_flag_in   = 1'b0;
               unique case (req_cmd)
                  CMD_START: begin
                     nonce_held_in  = {nonce_high_ff, nonce_low_ff};
                     acc_in         = '0;
                     ctr_in         = 32'd2;
                     len_in         = '0;
                     aes_ctl.expand = 1'b1;
                     state_in       = ST_EXPAND;
                  end
                  CMD_DATA: begin
                     if (nsat == 5'd0) begin
                        state_in = ST_RESP;
                     end else begin
                        aes_ctl.encrypt = 1'b1;
                        gh_go           = 1'b1;
                        state_in        = ST_RUN;
                     end
                  end
                  CMD_FINISH: begin
                     data_in         = {req_data_high, req_data_low};
                     aes_ctl.encrypt = 1'b1;
                     aes_block       = {nonce_held_ff, 32'd1};
                     gh_go           = 1'b1;
                     gh_x            = acc_ff ^ {64'd0, len_ff};
                     state_in        = ST_RUN;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_EXPAND: begin
            // hash key is the encryption of the zero block
            if (aes_done) begin
               aes_ctl.encrypt = 1'b1;
               aes_block       = '0;
               state_in        = ST_HASHKEY;
            end
         end
         ST_HASHKEY: begin
            if (aes_done) begin
               h_in     = aes_result;
               state_in = ST_RESP;
            end
         end
         ST_RUN: begin
            if (aes_flag_ff && gh_flag_ff) begin
               acc_in = gh_product;
               if (cmd_ff == CMD_DATA) begin
                  ctr_in       = ctr_ff + 32'd1;
                  len_in       = len_ff + {56'd0, cnt_ff, 3'b000};
                  res_plain_in = (data_ff ^ aes_result) & lead_mask(cnt_ff);
                  res_bytes_in = cnt_ff;
               end else begin
                  res_tag_in = (tag_diff == '0);
               end
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         acc_ff        <= '0;
         ctr_ff        <= '0;
         len_ff        <= '0;
         nonce_held_ff <= '0;
         aes_flag_ff   <= 1'b0;
         gh_flag_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         acc_ff        <= acc_in;
         ctr_ff        <= ctr_in;
         len_ff        <= len_in;
         nonce_held_ff <= nonce_held_in;
         aes_flag_ff   <= aes_flag_in;
         gh_flag_ff    <= gh_flag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      h_ff         <= h_in;
      cmd_ff       <= cmd_in;
      data_ff      <= data_in;
      cnt_ff       <= cnt_in;
      res_kind_ff  <= res_kind_in;
      res_plain_ff <= res_plain_in;
      res_bytes_ff <= res_bytes_in;
      res_tag_ff   <= res_tag_in;
      if (rsp_load) begin
         rsp_kind_ff  <= res_kind_ff;
         rsp_plain_ff <= res_plain_ff;
         rsp_bytes_ff <= res_bytes_ff;
         rsp_tag_ff   <= res_tag_ff;
      end
   end

   agd_aes_core u_aes (
      .clock    (clock),
      .reset    (reset),
      .ctl      (aes_ctl),
      .key_in   ({key_high_ff, key_low_ff}),
      .block_in (aes_block),
      .done     (aes_done),
      .result   (aes_result)
   );

   agd_ghash_mul u_ghash (
      .clock   (clock),
      .reset   (reset),
      .go      (gh_go),
      .x_in    (gh_x),
      .h_in    (h_ff),
      .done    (gh_done),
      .product (gh_product)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_plain_high  = rsp_plain_ff[127:64];
   assign rsp_plain_low   = rsp_plain_ff[63:0];
   assign rsp_valid_bytes = rsp_bytes_ff;
   assign rsp_tag_ok      = rsp_tag_ff;

   `AGD_ASSERT_NEXT(top_busy_after_cmd, clock, reset,
                    req_xfer && req_cmd != CMD_NONE, !req_ready)
   `AGD_ASSERT_SAME(top_units_launch_idle, clock, reset,
                    gh_go, state_ff == ST_IDLE && aes_ctl.encrypt)
   `AGD_ASSERT_SAME(top_load_free, clock, reset, rsp_load,
                    !rsp_valid_ff || rsp_ready)
endmodule

// File: sv/agd_ghash_mul.sv
// gf(2^128) multiplier in gcm bit order, eight bits of x per cycle
// depends on agd_pkg and the assertion macro header
`include "aes128_gcm_decrypt_unit_defines.svh"
module agd_ghash_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic [127:0] x_in,
   input  logic [127:0] h_in,
   output logic         done,
   output logic [127:0] product
);
   import agd_pkg::*;

   logic [127:0] x_ff, x_in_nx;
   logic [127:0] v_ff, v_in;
   logic [127:0] z_ff, z_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;

   // one byte of x per cycle against the shifting copy of h
   always_comb begin
      logic [127:0] z, v;
      logic         lsb;
      z = z_ff;
      v = v_ff;
      for (int j = 0; j < 8; j++) begin
         if (x_ff[127 - j]) z = z ^ v;
         lsb = v[0];
         v = v >> 1;
         if (lsb) v[127:120] = v[127:120] ^ GF_POLY;
      end
      x_in_nx = x_ff << 8;
      v_in    = v;
      z_in    = z;
      cnt_in  = cnt_ff + 4'd1;
      busy_in = busy_ff && (cnt_ff != 4'd15);
      done_in = busy_ff && (cnt_ff == 4'd15);
      if (go) begin
         x_in_nx = x_in;
         v_in    = h_in;
         z_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in_nx;
      v_ff <= v_in;
      z_ff <= z_in;
   end

   assign done    = done_ff;
   assign product = z_ff;

   `AGD_ASSERT_NEXT(gh_go_idle, clock, reset, go, busy_ff && !done_ff)
   `AGD_ASSERT_SAME(gh_done_count, clock, reset, done_ff, !busy_ff && cnt_ff == 4'd0)
   `AGD_ASSERT_SAME(gh_no_restart, clock, reset, go, !busy_ff)
endmodule

// File: sv/agd_aes_core.sv
// iterative aes-128 core: one round per cycle, key schedule stored once per start
// depends on agd_pkg and the assertion macro header
`include "aes128_gcm_decrypt_unit_defines.svh"
module agd_aes_core (
   input  logic                clock,
   input  logic                reset,
   input  agd_pkg::aes_ctl_type ctl,
   input  logic [127:0]        key_in,
   input  logic [127:0]        block_in,
   output logic                done,
   output logic [127:0]        result
);
   import agd_pkg::*;

   typedef enum logic [1:0] {
      AES_IDLE,
      AES_EXPAND,
      AES_ENCRYPT
   } aes_state_type;

   function automatic logic [7:0] dbl(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // one key schedule step from the previous round key
   function automatic logic [127:0] key_step(input logic [127:0] w, input logic [7:0] rc);
      logic [31:0] t, w0, w1, w2, w3;
      t  = {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
      w0 = w[127:96] ^ t;
      w1 = w[95:64] ^ w0;
      w2 = w[63:32] ^ w1;
      w3 = w[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   // sub bytes, shift rows, mix columns unless last, add round key
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic last);
      logic [7:0]   b [16];
      logic [7:0]   c [16];
      logic [7:0]   a0, all;
      logic [127:0] o;
      for (int i = 0; i < 16; i++) b[i] = SBOX[s[127 - 8*i -: 8]];
      for (int i = 0; i < 16; i++) c[i] = b[(i + 4*(i % 4)) % 16];
      if (!last) begin
         for (int j = 0; j < 4; j++) begin
            a0  = c[4*j];
            all = c[4*j] ^ c[4*j+1] ^ c[4*j+2] ^ c[4*j+3];
            c[4*j]   = c[4*j]   ^ dbl(c[4*j]   ^ c[4*j+1]) ^ all;
            c[4*j+1] = c[4*j+1] ^ dbl(c[4*j+1] ^ c[4*j+2]) ^ all;
            c[4*j+2] = c[4*j+2] ^ dbl(c[4*j+2] ^ c[4*j+3]) ^ all;
            c[4*j+3] = c[4*j+3] ^ dbl(c[4*j+3] ^ a0) ^ all;
         end
      end
      for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = c[i];
      return o ^ rk;
   endfunction

   aes_state_type state_ff, state_in;
   logic [3:0]    round_ff, round_in;
   logic [127:0]  work_ff, work_in;
   logic          done_ff, done_in;
   logic [127:0]  rk_ff [11];
   logic          rk_we;
   logic [3:0]    rk_idx;
   logic [127:0]  rk_wdata;
   logic [127:0]  rk_cur;

   assign rk_cur = rk_ff[round_ff];

   // sequencer over the shared round logic
   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      work_in  = work_ff;
      done_in  = 1'b0;
      rk_we    = 1'b0;
      rk_idx   = round_ff;
      rk_wdata = key_step(work_ff, RCON[round_ff]);
      unique case (state_ff)
         AES_IDLE: begin
            if (ctl.expand) begin
               rk_we    = 1'b1;
               rk_idx   = '0;
               rk_wdata = key_in;
               work_in  = key_in;
               round_in = 4'd1;
               state_in = AES_EXPAND;
            end else if (ctl.encrypt) begin
               work_in  = block_in ^ rk_ff[0];
               round_in = 4'd1;
               state_in = AES_ENCRYPT;
            end
         end
         AES_EXPAND: begin
            rk_we    = 1'b1;
            work_in  = rk_wdata;
            round_in = round_ff + 4'd1;
            if (round_ff == 4'd10) begin
               done_in  = 1'b1;
               state_in = AES_IDLE;
            end
         end
         AES_ENCRYPT: begin
            work_in  = aes_round(work_ff, rk_cur, round_ff == 4'd10);
            round_in = round_ff + 4'd1;
            if (round_ff == 4'd10) begin
               done_in  = 1'b1;
               state_in = AES_IDLE;
            end
         end
         default: state_in = AES_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AES_IDLE;
         done_ff  <= 1'b0;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         round_ff <= round_in;
      end
      work_ff <= work_in;
      if (rk_we) rk_ff[rk_idx] <= rk_wdata;
   end

   assign done   = done_ff;
   assign result = work_ff;

   `AGD_ASSERT_SAME(aes_ctl_excl, clock, reset, 1'b1, !(ctl.expand && ctl.encrypt))
   `AGD_ASSERT_SAME(aes_ctl_idle, clock, reset, ctl.expand || ctl.encrypt, state_ff == AES_IDLE)
   `AGD_ASSERT_SAME(aes_round_range, clock, reset, state_ff != AES_IDLE,
                    round_ff != 4'd0 && round_ff <= 4'd10)
endmodule
